>>> rtl/core/shabsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Transaction types, the control structs between the sequencer and the
// compression engine, and the SHA-256 constants and bit functions.
// ----------------------------------------------------------------------------
package shabsh_pkg;

    // One input transaction: a message byte and its marks.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    // One output transaction: a digest word and its position.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Commands from the sequencer to the compression engine.
    typedef struct packed {
        logic        wr;           // write one message byte into the block
        logic [5:0]  wr_idx;       // byte position in the block
        logic [7:0]  wr_byte;
        logic        pad;          // rewrite the block with padding
        logic [5:0]  pad_fill;     // first byte position that is not message
        logic        pad_len_en;   // place the bit length in the last eight bytes
        logic        pad_zero_all; // the block holds no message bytes at all
        logic [63:0] msg_bits;     // message length in bits
        logic        start;        // run the 64 rounds over the block
        logic        reinit;       // load the initial hash values
    } t_core_cmd;

    // Status from the compression engine.
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    localparam int BLOCK_BYTES = 64;
    localparam int LENGTH_POS  = 56;
    localparam int NUM_ROUNDS  = 64;

    // Initial hash values.
    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // Round constants.
    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] v;
        case (t)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Rotate right by a constant amount.
    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Rotation sum over working word a.
    function automatic logic [31:0] sum_a(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    // Rotation sum over working word e.
    function automatic logic [31:0] sum_e(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // Schedule mix of the word fifteen places back.
    function automatic logic [31:0] mix_w15(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    // Schedule mix of the word two places back.
    function automatic logic [31:0] mix_w2(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> rtl/core/shabsh_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Holds the 16-word block and message schedule window, the eight working
// words and the chaining words. One round unit runs 64 times per block.
// ----------------------------------------------------------------------------
module shabsh_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  shabsh_pkg::t_core_cmd  i_cmd,
    output shabsh_pkg::t_core_stat o_stat,
    output logic [7:0][31:0]       o_chain
);
    import shabsh_pkg::*;

    // Block words; during the rounds this is the schedule window, word 0 is w[t].
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_fin;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;
    logic [31:0] n_wnew;
    logic [31:0] n_pad [16];
    logic [4:0]  wr_shift;

    // Round arithmetic.
    always_comb begin
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj     = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + sum_e(r_v[4]) + ch + round_k(r_rnd) + r_w[0];
        t2     = sum_a(r_v[0]) + mj;
        n_wnew = mix_w2(r_w[14]) + r_w[9] + mix_w15(r_w[1]) + r_w[0];
    end

    // Padded block image: end marker, zeros and the bit length.
    always_comb begin
        for (int p = 0; p < BLOCK_BYTES; p++) begin
            logic [7:0] b;
            b = r_w[p / 4][8 * (3 - (p % 4)) +: 8];
            if (i_cmd.pad_zero_all || (6'(p) > i_cmd.pad_fill)) begin
                b = 8'h00;
            end else if (6'(p) == i_cmd.pad_fill) begin
                b = 8'h80;
            end
            if (i_cmd.pad_len_en && (p >= LENGTH_POS)) begin
                b = i_cmd.msg_bits[8 * ((BLOCK_BYTES - 1 - p) & 7) +: 8];
            end
            n_pad[p / 4][8 * (3 - (p % 4)) +: 8] = b;
        end
    end

    // Bit offset of a byte lane, most significant lane first.
    assign wr_shift = {~i_cmd.wr_idx[1:0], 3'b000};

    // Sequencer and state of the engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rnd  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= init_word(3'(i));
            end
        end else begin
            if (i_cmd.reinit) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= init_word(3'(i));
                end
            end
            if (i_cmd.wr) begin
                r_w[i_cmd.wr_idx[5:2]][wr_shift +: 8] <= i_cmd.wr_byte;
            end
            if (i_cmd.pad) begin
                for (int i = 0; i < 16; i++) begin
                    r_w[i] <= n_pad[i];
                end
            end
            if (i_cmd.start) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
                r_rnd  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_v[0] <= t1 + t2;
                r_v[1] <= r_v[0];
                r_v[2] <= r_v[1];
                r_v[3] <= r_v[2];
                r_v[4] <= r_v[3] + t1;
                r_v[5] <= r_v[4];
                r_v[6] <= r_v[5];
                r_v[7] <= r_v[6];
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= n_wnew;
                r_rnd   <= r_rnd + 6'd1;
                if (r_rnd == 6'(NUM_ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            // Fold the working words into the chaining words.
            if (r_fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
                r_fin <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_busy | r_fin;
    assign o_stat.done = r_fin;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_chain[i] = r_h[i];
        end
    end

    // A block is only started or rewritten while the engine is quiet.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start || i_cmd.wr || i_cmd.pad) |-> (!r_busy && !r_fin))
        else $error("block changed while the rounds run");

    // The fold step follows the last round.
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_rnd == 6'(NUM_ROUNDS - 1))) |=> r_fin)
        else $error("last round not followed by the fold step");

    // Rounds and the fold step never overlap.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_fin))
        else $error("rounds and fold step active together");

endmodule

>>> rtl/core/sha256_byte_stream_hasher.sv
// Input: a byte without end mark is taken while the sequencer is idle; the 64th byte of a block
// starts the 64 rounds of the shared round unit and the fold step; input stalls until they end.
// End of message: per final block (one or two), a padding step, the rounds and the fold; then each
// of the eight digest words is registered and held on the output until it is taken.
// Reset: synchronous, active low; clears control state and loads the initial hash values.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Packs message bytes into 64-byte blocks, compresses each full block, pads
// the final block and returns the eight digest words as output transactions.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  shabsh_pkg::t_in_item  i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output shabsh_pkg::t_out_item o_out_item,
    input  logic                  i_out_stall
);
    import shabsh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_PAD1 = 3'd2;
    localparam logic [2:0] S_PAD2 = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [1:0] AFT_IDLE = 2'd0;
    localparam logic [1:0] AFT_PAD1 = 2'd1;
    localparam logic [1:0] AFT_PAD2 = 2'd2;
    localparam logic [1:0] AFT_EMIT = 2'd3;

    logic [2:0]  r_state;
    logic [1:0]  r_after;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [2:0]  r_widx;
    logic        r_out_valid;
    t_out_item   r_out_item;

    t_core_cmd        cmd;
    t_core_stat       stat;
    logic [7:0][31:0] chain;
    logic             in_accept;
    logic             out_accept;
    logic             block_full;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_accept = r_out_valid && !i_out_stall;
    assign block_full = (r_fill == 6'(BLOCK_BYTES - 1));

    // Commands to the compression engine.
    always_comb begin
        cmd          = '0;
        cmd.wr_idx   = r_fill;
        cmd.wr_byte  = i_in_item.byte_value;
        cmd.pad_fill = r_fill;
        cmd.msg_bits = {r_count, 3'b000};
        case (r_state)
            S_IDLE: begin
                cmd.wr    = in_accept && i_in_item.byte_present;
                cmd.start = in_accept && i_in_item.byte_present && block_full;
            end
            S_PAD1: begin
                cmd.pad        = 1'b1;
                cmd.pad_len_en = (r_fill < 6'(LENGTH_POS));
                cmd.start      = 1'b1;
            end
            S_PAD2: begin
                cmd.pad          = 1'b1;
                cmd.pad_zero_all = 1'b1;
                cmd.pad_len_en   = 1'b1;
                cmd.start        = 1'b1;
            end
            S_EMIT: begin
                cmd.reinit = out_accept && (r_widx == 3'd7);
            end
            default: begin
            end
        endcase
    end

    shabsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_chain (chain)
    );

    // Message sequencer and digest output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= AFT_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_in_item.byte_present) begin
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + 61'd1;
                        end
                        if (i_in_item.byte_present && block_full) begin
                            r_state <= S_RUN;
                            r_after <= i_in_item.end_of_message ? AFT_PAD1 : AFT_IDLE;
                        end else if (i_in_item.end_of_message) begin
                            r_state <= S_PAD1;
                        end
                    end
                end
                S_PAD1: begin
                    r_state <= S_RUN;
                    r_after <= (r_fill >= 6'(LENGTH_POS)) ? AFT_PAD2 : AFT_EMIT;
                end
                S_PAD2: begin
                    r_state <= S_RUN;
                    r_after <= AFT_EMIT;
                end
                S_RUN: begin
                    if (stat.done) begin
                        case (r_after)
                            AFT_IDLE: r_state <= S_IDLE;
                            AFT_PAD1: r_state <= S_PAD1;
                            AFT_PAD2: r_state <= S_PAD2;
                            default: begin
                                r_state     <= S_EMIT;
                                r_widx      <= '0;
                                r_out_valid <= 1'b0;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid) begin
                        r_out_item.digest_word <= chain[r_widx];
                        r_out_item.word_index  <= r_widx;
                        r_out_item.last_word   <= (r_widx == 3'd7);
                        r_out_valid            <= 1'b1;
                    end else if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_widx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_fill  <= '0;
                            r_count <= '0;
                            r_widx  <= '0;
                        end else begin
                            r_widx <= r_widx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Digest words only leave while the digest is being returned.
    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_EMIT))
        else $error("output valid outside digest return");

    // The final digest word ends the message.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && r_out_item.last_word) |=> ((r_state == S_IDLE) && (r_count == 61'd0)))
        else $error("state not cleared after the final digest word");

    // The engine only finishes a block the sequencer is waiting on.
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> (r_state == S_RUN))
        else $error("compression finished outside the run state");

    // The engine is quiet whenever a transaction can be taken.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !stat.busy)
        else $error("engine busy while input is open");

endmodule
